// ===== rtl/set_assoc_lru_cache_lookup_macros.svh =====
// Assertion macros used by the cache lookup top level.
`ifndef SET_ASSOC_LRU_CACHE_LOOKUP_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_LOOKUP_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define SALC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define SALC_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/salc_pkg.sv =====
// Types and constants of the set-associative LRU cache lookup.
`default_nettype none

package salc_pkg;

  localparam int SETS      = 512;
  localparam int WAYS      = 8;
  localparam int ADDR_W    = 64;
  localparam int OFFSET_W  = 5;
  localparam int INDEX_W   = $clog2(SETS + 1) - 1;
  localparam int ROWS      = 1 << INDEX_W;
  localparam int TAG_W     = ADDR_W - OFFSET_W - INDEX_W;
  localparam int CFG_W     = 4;
  localparam int WAY_CNT_W = $clog2(WAYS + 1);
  localparam int WAY_IDX_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int RANK_W    = 3;
  localparam int RANK_TDATA_W = 8;
  localparam logic [CFG_W-1:0] WAYS_RESET = CFG_W'(8);

  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
  } way_entry_t;

  typedef way_entry_t [WAYS-1:0] set_row_t;

  localparam int ROW_W = $bits(set_row_t);

  typedef struct packed {
    logic              hit;
    logic [RANK_W-1:0] rank;
  } lookup_res_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } lookup_state_e;

endpackage

`default_nettype wire

// ===== rtl/salc_row_ram.sv =====
// Simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module salc_row_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 408
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/salc_lru_update.sv =====
// Tag compare and recency reordering of one set row.
`default_nettype none

module salc_lru_update (
  input  wire salc_pkg::set_row_t              row_i,
  input  wire logic [salc_pkg::TAG_W-1:0]      tag_i,
  input  wire logic [salc_pkg::WAY_CNT_W-1:0]  ways_i,
  output salc_pkg::set_row_t                   row_o,
  output salc_pkg::lookup_res_t                res_o
);

  import salc_pkg::*;

  logic [WAYS-1:0]      hit_vec;
  logic                 found;
  logic [WAY_IDX_W-1:0] pos;
  logic [WAY_CNT_W-1:0] top;

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      hit_vec[i] = row_i[i].valid && (row_i[i].tag == tag_i) &&
                   (WAY_CNT_W'(i) < ways_i);
    end
  end

  always_comb begin
    found = 1'b0;
    pos   = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (!found && hit_vec[i]) begin
        found = 1'b1;
        pos   = WAY_IDX_W'(i);
      end
    end
  end

  assign top = found ? WAY_CNT_W'(pos) : (ways_i - WAY_CNT_W'(1));

  always_comb begin
    row_o[0].valid = 1'b1;
    row_o[0].tag   = tag_i;
    for (int i = 1; i < WAYS; i++) begin
      if (WAY_CNT_W'(i) <= top) begin
        row_o[i] = row_i[i-1];
      end else begin
        row_o[i] = row_i[i];
      end
    end
  end

  assign res_o.hit  = found;
  assign res_o.rank = found ? RANK_W'(pos) : '0;

endmodule

`default_nettype wire

// ===== rtl/set_assoc_lru_cache_lookup.sv =====
// Set-associative cache lookup with true LRU replacement; top level.
//
// Each address transfer selects a set row from one on-chip memory that holds the tags and
// valid bits of all ways of a set. The row is read in the cycle of the transfer, compared
// and reordered in the next cycle and written back once the result register is free; a new
// address is taken only after that write-back. The result waits in an output register and
// a stalled result holds the write-back until it is taken. After reset the block clears
// all 512 rows, one row a cycle, before it takes its first address; the ways register may
// be written during that time. Ways register writes take effect on the next address; the
// user is to make them only while no lookup is in progress; the block does not enforce it.
`default_nettype none

module set_assoc_lru_cache_lookup (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [salc_pkg::CFG_W-1:0]    cfg_data_i,    // ways_in_use
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [salc_pkg::ADDR_W-1:0]   s_axis_tdata,  // address
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [salc_pkg::RANK_TDATA_W-1:0]  m_axis_tdata,  // hit_rank, zero fill
  output logic                               m_axis_tuser   // hit
);

  import salc_pkg::*;

  lookup_state_e        state_q, state_d;
  logic [INDEX_W-1:0]   clr_cnt_q, clr_cnt_d;
  logic [CFG_W-1:0]     ways_q;
  logic [WAY_CNT_W-1:0] ways_act;
  logic [INDEX_W-1:0]   idx_q;
  logic [TAG_W-1:0]     tag_q;
  logic                 m_valid_q, m_valid_d;
  lookup_res_t          res_q;
  lookup_res_t          upd_res;
  set_row_t             rd_row;
  set_row_t             upd_row;
  logic                 in_xfer;
  logic                 lookup_go;
  logic                 clear_done;
  logic                 ram_we;
  logic [INDEX_W-1:0]   ram_waddr;
  logic [ROW_W-1:0]     ram_wdata;
  logic [ROW_W-1:0]     ram_rdata;

  assign cfg_ready_o = 1'b1;
  assign in_xfer     = s_axis_tvalid && s_axis_tready;
  assign lookup_go   = !m_valid_q || m_axis_tready;
  assign clear_done  = (clr_cnt_q == INDEX_W'(ROWS - 1));

  always_comb begin
    if (ways_q == '0) begin
      ways_act = WAY_CNT_W'(1);
    end else if (int'(ways_q) > WAYS) begin
      ways_act = WAY_CNT_W'(WAYS);
    end else begin
      ways_act = WAY_CNT_W'(ways_q);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clear_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (lookup_go) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = idx_q;
    ram_wdata     = ROW_W'(upd_row);
    clr_cnt_d     = clr_cnt_q;
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = '0;
        clr_cnt_d = clr_cnt_q + INDEX_W'(1);
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
      end
      ST_LOOKUP: begin
        ram_we = lookup_go;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (m_axis_tvalid && m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    if (state_q == ST_LOOKUP && lookup_go) begin
      m_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
      ways_q    <= WAYS_RESET;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      m_valid_q <= m_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        ways_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      idx_q <= s_axis_tdata[OFFSET_W +: INDEX_W];
      tag_q <= s_axis_tdata[OFFSET_W + INDEX_W +: TAG_W];
    end
    if (state_q == ST_LOOKUP && lookup_go) begin
      res_q <= upd_res;
    end
  end

  salc_row_ram #(
    .DEPTH (ROWS),
    .WIDTH (ROW_W)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_xfer),
    .raddr_i (s_axis_tdata[OFFSET_W +: INDEX_W]),
    .rdata_o (ram_rdata)
  );

  assign rd_row = set_row_t'(ram_rdata);

  salc_lru_update u_lru_update (
    .row_i  (rd_row),
    .tag_i  (tag_q),
    .ways_i (ways_act),
    .row_o  (upd_row),
    .res_o  (upd_res)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = res_q.hit;
  assign m_axis_tdata  = RANK_TDATA_W'(res_q.rank);

`include "set_assoc_lru_cache_lookup_macros.svh"

  `SALC_ASSERT_ALWAYS(a_no_input_while_clearing, (state_q == ST_CLEAR) |-> !s_axis_tready, "address taken during clearing pass")
  `SALC_ASSERT(a_result_after_lookup, (state_q == ST_LOOKUP && lookup_go) |=> m_axis_tvalid, "lookup finished without a result")
  `SALC_ASSERT(a_write_only_when_owned, ram_we |-> (state_q == ST_CLEAR || state_q == ST_LOOKUP), "row memory written outside clearing or lookup")
  `SALC_ASSERT(a_miss_rank_zero, (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0), "miss carries a non-zero rank")
  `SALC_ASSERT(a_lookup_follows_transfer, in_xfer |=> (state_q == ST_LOOKUP), "address transfer did not start a lookup")

endmodule

`default_nettype wire

// ===== test/salc_result_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the cache lookup: tracks the LRU sets, predicts each result and compares it.
module salc_result_checker (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_valid_i,
  input  wire logic                                cfg_ready_i,
  input  wire logic [salc_pkg::CFG_W-1:0]          cfg_data_i,    // ways_in_use
  input  wire logic                                s_axis_tvalid,
  input  wire logic                                s_axis_tready,
  input  wire logic [salc_pkg::ADDR_W-1:0]         s_axis_tdata,  // address
  input  wire logic                                m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  input  wire logic [salc_pkg::RANK_TDATA_W-1:0]   m_axis_tdata,  // hit_rank, zero fill
  input  wire logic                                m_axis_tuser,  // hit
  output int                                       error_count_o,
  output int                                       pending_o
);
  import salc_pkg::*;

  logic [TAG_W-1:0] set_tags  [ROWS][WAYS];
  logic             set_valid [ROWS][WAYS];
  logic [CFG_W-1:0] ways_setting;
  lookup_res_t      expected_lookups [$];
  int               mismatches;

  function automatic lookup_res_t lru_lookup(input logic [ADDR_W-1:0] addr);
    logic [INDEX_W-1:0] row;
    logic [TAG_W-1:0]   tag;
    int                 active;
    int                 pos;
    int                 top;
    lookup_res_t        res;
    row = addr[OFFSET_W +: INDEX_W];
    tag = addr[ADDR_W-1 -: TAG_W];
    if (ways_setting < 1) begin
      active = 1;
    end else if (ways_setting > WAYS) begin
      active = WAYS;
    end else begin
      active = int'(ways_setting);
    end
    pos = active;
    for (int i = 0; i < active; i++) begin
      if (pos == active && set_valid[row][i] && set_tags[row][i] == tag) begin
        pos = i;
      end
    end
    top = (pos < active) ? pos : active - 1;
    for (int i = top; i >= 1; i--) begin
      set_tags[row][i]  = set_tags[row][i-1];
      set_valid[row][i] = set_valid[row][i-1];
    end
    set_tags[row][0]  = tag;
    set_valid[row][0] = 1'b1;
    res.hit  = (pos < active);
    res.rank = res.hit ? RANK_W'(pos) : '0;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lookup_res_t want;
    if (!rst_ni) begin
      for (int r = 0; r < ROWS; r++) begin
        for (int w = 0; w < WAYS; w++) begin
          set_valid[r][w] = 1'b0;
        end
      end
      ways_setting = WAYS_RESET;
      expected_lookups.delete();
      mismatches = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_lookups.size() == 0) begin
          mismatches++;
          $display("%0t: result transfer with no lookup outstanding, expected none, actual hit %0b tdata 0x%02h",
                   $time, m_axis_tuser, m_axis_tdata);
        end else begin
          want = expected_lookups.pop_front();
          if (m_axis_tuser !== want.hit) begin
            mismatches++;
            $display("%0t: hit mismatch, expected %0b, actual %0b", $time, want.hit, m_axis_tuser);
          end
          if (m_axis_tdata[RANK_W-1:0] !== want.rank) begin
            mismatches++;
            $display("%0t: hit_rank mismatch, expected %0d, actual %0d",
                     $time, want.rank, m_axis_tdata[RANK_W-1:0]);
          end
          if (m_axis_tdata[RANK_TDATA_W-1:RANK_W] !== '0) begin
            mismatches++;
            $display("%0t: tdata fill mismatch, expected 0, actual 0x%0h",
                     $time, m_axis_tdata[RANK_TDATA_W-1:RANK_W]);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_lookups.push_back(lru_lookup(s_axis_tdata));
      end
      if (cfg_valid_i && cfg_ready_i) begin
        ways_setting = cfg_data_i;
      end
    end
    error_count_o <= mismatches;
    pending_o     <= expected_lookups.size();
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench top for the cache lookup: clock, reset, address and ways stimulus, and the verdict.
module tb_top;
  import salc_pkg::*;

  localparam int TAG_POOL    = 10;
  localparam int ROW_POOL    = 3;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 36;
  localparam int HOLD_CYCLES = 100;
  localparam logic [INDEX_W-1:0] FILL_ROW = INDEX_W'(5);
  localparam logic [PHASES*CFG_W-1:0] WAY_SETTINGS =
    {4'd6, 4'd12, 4'd3, 4'd8, 4'd7, 4'd9, 4'd4, 4'd8, 4'd1, 4'd15, 4'd0, 4'd2};

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CFG_W-1:0]        cfg_data_i;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [ADDR_W-1:0]       s_axis_tdata;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  logic [RANK_TDATA_W-1:0] m_axis_tdata;
  logic                    m_axis_tuser;
  int                      error_count;
  int                      pending;

  logic                    src_quiet;
  logic                    sink_quiet;
  logic                    hold_output;
  logic [TAG_W-1:0]        tag_pool [TAG_POOL];
  logic [INDEX_W-1:0]      row_pool [ROW_POOL];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  set_assoc_lru_cache_lookup dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  salc_result_checker results_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .error_count_o (error_count),
    .pending_o     (pending)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 96) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [ADDR_W-1:0] address_of(input logic [TAG_W-1:0] tag,
                                                   input logic [INDEX_W-1:0] row);
    logic [ADDR_W-1:0] addr;
    addr = {$urandom, $urandom};
    addr[ADDR_W-1 -: TAG_W]    = tag;
    addr[OFFSET_W +: INDEX_W]  = row;
    return addr;
  endfunction

  // Mostly a small pool of tags on a few sets so that lines are reused; the rest is noise.
  function automatic logic [ADDR_W-1:0] pick_address();
    if ($urandom_range(0, 99) < 85) begin
      return address_of(tag_pool[$urandom_range(0, TAG_POOL-1)],
                        row_pool[$urandom_range(0, ROW_POOL-1)]);
    end
    return {$urandom, $urandom};
  endfunction

  task automatic send_address(input logic [ADDR_W-1:0] addr);
    int gap;
    gap = src_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= addr;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_ways(input logic [CFG_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int stall;
    int run;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_output) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_output = 1'b0;
      end
      stall = sink_quiet ? 0 : pick_gap();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      run = $urandom_range(1, 12);
      repeat (run - 1) @(negedge clk_i);
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    src_quiet     = 1'b0;
    sink_quiet    = 1'b0;
    hold_output   = 1'b0;
    for (int i = 0; i < TAG_POOL; i++) begin
      tag_pool[i] = TAG_W'({$urandom, $urandom});
    end
    for (int i = 0; i < ROW_POOL; i++) begin
      row_pool[i] = INDEX_W'($urandom);
    end
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part with the ways register at its reset value.
    send_address('0);
    send_address(ADDR_W'(5'h1f));
    send_address('1);
    send_address('1);
    for (int k = 1; k <= 8; k++) begin
      send_address(address_of(TAG_W'(k), FILL_ROW));
    end
    send_address(address_of(TAG_W'(1), FILL_ROW));
    send_address(address_of(TAG_W'(9), FILL_ROW));
    send_address(address_of(TAG_W'(2), FILL_ROW));
    send_address(address_of(TAG_W'(5), FILL_ROW));
    send_address(address_of({1'b1, {(TAG_W-1){1'b0}}}, '0));
    send_address(address_of('0, INDEX_W'(ROWS-1)));
    // Shrinking the ways hides the older lines, regrowing shows them again.
    wait_idle();
    write_ways(CFG_W'(2));
    send_address(address_of(TAG_W'(6), FILL_ROW));
    send_address(address_of(TAG_W'(6), FILL_ROW));
    wait_idle();
    write_ways(CFG_W'(8));
    send_address(address_of(TAG_W'(7), FILL_ROW));

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      write_ways(WAY_SETTINGS[p*CFG_W +: CFG_W]);
      src_quiet  = (p == 4);
      sink_quiet = (p == 4);
      if (p == 2) begin
        hold_output = 1'b1;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_address(pick_address());
      end
    end

    wait_idle();
    repeat (20) @(negedge clk_i);
    if (error_count == 0 && pending == 0) begin
      $display("** set_assoc_lru_cache_lookup: PASSED **");
    end else begin
      $display("** set_assoc_lru_cache_lookup: FAILED **");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("** set_assoc_lru_cache_lookup: FAILED **");
    $finish;
  end

endmodule

// ===== set_assoc_lru_cache_lookup.f =====
+incdir+rtl
rtl/salc_pkg.sv
rtl/salc_row_ram.sv
rtl/salc_lru_update.sv
rtl/set_assoc_lru_cache_lookup.sv
test/salc_result_checker.sv
test/tb_top.sv
